### design/ems_pfm_pkg.sv
package ems_pfm_pkg;

    localparam int BASE_PAGES = 24;
    localparam int CARD_PAGES = 192;

    localparam int NUM_PAGE_REGS = 8;
    localparam int NUM_SLOTS     = 4;
    localparam int ADDR_W        = 22;
    localparam int SLOT_OFS_W    = 14;

    localparam logic [ADDR_W-1:0] BASE_PAGE_ORIGIN = 22'h0A0000;
    localparam logic [ADDR_W:0]   CARD_TOP         = 23'h400000;
    localparam logic [3:0]        WINDOW_SEG       = 4'hD;

    typedef enum logic [1:0] {
        CMD_PORT_RD = 2'd0,
        CMD_PORT_WR = 2'd1,
        CMD_MEM_RD  = 2'd2,
        CMD_MEM_WR  = 2'd3
    } cmd_t;

    localparam logic [9:0] BASE_LIMIT = 10'(BASE_PAGES);
    localparam logic [9:0] CARD_LIMIT = 10'(BASE_PAGES + CARD_PAGES);

    // Translates a page register write into a slot base; zero means unmapped.
    function automatic logic [ADDR_W-1:0] page_to_base(
        input logic       bank,
        input logic [7:0] value,
        input logic       card_en
    );
        logic [9:0]      page;
        logic [9:0]      card_idx;
        logic [ADDR_W:0] card_off;
        logic [ADDR_W:0] base_sum;
        page     = {1'b0, bank, value[6:0]};
        card_idx = page - BASE_LIMIT + 10'd1;
        card_off = {card_idx[8:0], SLOT_OFS_W'(0)};
        base_sum = {1'b0, BASE_PAGE_ORIGIN} + {4'd0, page[4:0], SLOT_OFS_W'(0)};
        if (!value[7])
        begin
            page_to_base = '0;
        end
        else if (page < BASE_LIMIT)
        begin
            page_to_base = base_sum[ADDR_W-1:0];
        end
        else if (card_en && (page < CARD_LIMIT) && (card_idx[9] == 1'b0)
                 && (card_off < CARD_TOP))
        begin
            page_to_base = ADDR_W'(CARD_TOP - card_off);
        end
        else
        begin
            page_to_base = '0;
        end
    endfunction

endpackage

### design/ems_pfm_if.sv
interface ems_pfm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] io_port;
    logic [19:0] mem_addr;
    logic [7:0]  wdata;

    modport source (output valid, cmd, io_port, mem_addr, wdata, input ready);
    modport sink (input valid, cmd, io_port, mem_addr, wdata, output ready);
endinterface

interface ems_pfm_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reg_rdata;
    logic        hit;
    logic [21:0] backing_addr;
    logic        mem_write_enable;
    logic [7:0]  mem_wdata;

    modport source (output valid, reg_rdata, hit, backing_addr, mem_write_enable, mem_wdata,
                    input ready);
    modport sink (input valid, reg_rdata, hit, backing_addr, mem_write_enable, mem_wdata,
                  output ready);
endinterface

### design/ems_page_frame_mapper_core.sv
// Channel   Direction  Contents
// req       in         cmd, io_port, mem_addr, wdata (valid/ready)
// rsp       out        reg_rdata, hit, backing_addr, mem_write_enable, mem_wdata
// apb       in         card_enable at byte address 0
//
// Each transaction has an accept step and an execute step: accepting issues the page register
// and slot base memory reads, and execute uses the read data and writes back.
// A finished result waits in the output register; a new request is accepted
// meanwhile and stalls in the execute state only if that register is still full.
// Reset clears all page registers and slot bases through per-entry valid bits.
module ems_page_frame_mapper_core
    import ems_pfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ems_pfm_req_if.sink         req,
    ems_pfm_rsp_if.source       rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   card_en_reg;

    logic [7:0]        page_mem [NUM_PAGE_REGS];
    logic [ADDR_W-1:0] slot_mem [NUM_SLOTS];
    logic [NUM_PAGE_REGS-1:0] page_vld_reg;
    logic [NUM_SLOTS-1:0]     slot_vld_reg;

    logic [1:0]        cmd_reg;
    logic [2:0]        ridx_reg;
    logic [19:0]       addr_reg;
    logic [7:0]        wdata_reg;
    logic [7:0]        page_rd_reg;
    logic [ADDR_W-1:0] slot_rd_reg;
    logic              page_ok_reg;
    logic              slot_ok_reg;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        reg_rdata_reg, reg_rdata_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] backing_reg, backing_next;
    logic              mwe_reg, mwe_next;
    logic [7:0]        mwdata_reg, mwdata_next;

    logic              in_fire;
    logic              advance;
    logic [2:0]        in_ridx;
    logic [1:0]        in_slot;
    logic              page_wr;
    logic [ADDR_W-1:0] new_base;
    logic [7:0]        page_val;
    logic [ADDR_W-1:0] slot_val;
    logic              in_window;
    logic [ADDR_W-1:0] xlat_addr;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata  = (paddr[2] == 1'b0) ? {31'd0, card_en_reg} : 32'd0;

    assign req.ready = (state_reg == ST_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign advance   = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    assign in_ridx = {req.io_port[4], req.io_port[15:14]};
    // Port writes do not use the slot memory read data, so the read slot index comes from the address.
    assign in_slot = req.mem_addr[15:14];

    assign page_wr  = advance && (cmd_t'(cmd_reg) == CMD_PORT_WR);
    assign new_base = page_to_base(ridx_reg[2], wdata_reg, card_en_reg);

    assign page_val  = page_ok_reg ? page_rd_reg : 8'd0;
    assign slot_val  = slot_ok_reg ? slot_rd_reg : '0;
    assign in_window = (addr_reg[19:16] == WINDOW_SEG) && (slot_val != '0);
    assign xlat_addr = slot_val + ADDR_W'(addr_reg[SLOT_OFS_W-1:0]);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (advance)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            card_en_reg   <= 1'b0;
            page_vld_reg  <= '0;
            slot_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                card_en_reg <= pwdata[0];
            end
            if (page_wr)
            begin
                page_vld_reg[ridx_reg]      <= 1'b1;
                slot_vld_reg[ridx_reg[1:0]] <= 1'b1;
            end
        end
    end

    // Page register and slot base memories, read into registers when a request is accepted.
    always_ff @(posedge clk)
    begin
        if (page_wr)
        begin
            page_mem[ridx_reg]      <= wdata_reg;
            slot_mem[ridx_reg[1:0]] <= new_base;
        end
        if (in_fire)
        begin
            cmd_reg     <= req.cmd;
            ridx_reg    <= in_ridx;
            addr_reg    <= req.mem_addr;
            wdata_reg   <= req.wdata;
            page_rd_reg <= page_mem[in_ridx];
            slot_rd_reg <= slot_mem[in_slot];
            page_ok_reg <= page_vld_reg[in_ridx];
            slot_ok_reg <= slot_vld_reg[in_slot];
        end
    end

    always_comb
    begin
        reg_rdata_next = 8'd0;
        hit_next       = 1'b0;
        backing_next   = '0;
        mwe_next       = 1'b0;
        mwdata_next    = 8'd0;
        case (cmd_t'(cmd_reg))
            CMD_PORT_RD:
            begin
                reg_rdata_next = page_val;
            end
            CMD_MEM_RD, CMD_MEM_WR:
            begin
                if (in_window)
                begin
                    hit_next     = 1'b1;
                    backing_next = xlat_addr;
                    if (cmd_t'(cmd_reg) == CMD_MEM_WR)
                    begin
                        mwe_next    = 1'b1;
                        mwdata_next = wdata_reg;
                    end
                end
            end
            default:
            begin
                reg_rdata_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            reg_rdata_reg <= reg_rdata_next;
            hit_reg       <= hit_next;
            backing_reg   <= backing_next;
            mwe_reg       <= mwe_next;
            mwdata_reg    <= mwdata_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.reg_rdata        = reg_rdata_reg;
    assign rsp.hit              = hit_reg;
    assign rsp.backing_addr     = backing_reg;
    assign rsp.mem_write_enable = mwe_reg;
    assign rsp.mem_wdata        = mwdata_reg;

endmodule

### test/ems_page_frame_mapper_core_tb.sv
`timescale 1ns / 100ps

module ems_page_frame_mapper_core_tb;
    import ems_pfm_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int          PHASE_ITEMS      = 300;
    localparam logic [2:0]  CARD_ENABLE_ADDR = 3'd0;
    localparam logic [19:0] WINDOW_START     = 20'hD0000;
    localparam logic [19:0] WINDOW_END       = 20'hDFFFF;
    localparam int unsigned SLOT_BYTES       = 32'h4000;
    localparam int unsigned BASE_ORIGIN      = 32'hA0000;
    localparam int unsigned CARD_CEILING     = 32'h400000;

    typedef struct {
        logic [7:0]  reg_rdata;
        logic        hit;
        logic [21:0] backing_addr;
        logic        mem_write_enable;
        logic [7:0]  mem_wdata;
    } translation_t;

    // Tracks the page registers and slot bases and queues the translation
    // that each accepted request should produce.
    class window_map_model;
        logic [7:0]   page_regs [NUM_PAGE_REGS];
        logic [21:0]  slot_base [NUM_SLOTS];
        bit           card_en;
        translation_t pending_translations [$];
        int unsigned  failures;

        function new();
            foreach (page_regs[i]) page_regs[i] = '0;
            foreach (slot_base[i]) slot_base[i] = '0;
            card_en  = 1'b0;
            failures = 0;
        endfunction

        function logic [21:0] frame_base(bit bank, logic [7:0] value);
            int unsigned page;
            int unsigned offset;
            page = value[6:0] + (bank ? 128 : 0);
            if (!value[7])
            begin
                return '0;
            end
            if (page < BASE_PAGES)
            begin
                return 22'(BASE_ORIGIN + page * SLOT_BYTES);
            end
            if (card_en && page < BASE_PAGES + CARD_PAGES)
            begin
                // Card pages fill downward from the top of the 4 MiB space.
                offset = (page - BASE_PAGES + 1) * SLOT_BYTES;
                if (offset >= CARD_CEILING)
                begin
                    return '0;
                end
                return 22'(CARD_CEILING - offset);
            end
            return '0;
        endfunction

        function void accept_request(cmd_t op, logic [15:0] port, logic [19:0] addr,
                                     logic [7:0] wdata);
            logic [2:0]   sel;
            logic [21:0]  base;
            translation_t t;
            sel = {port[4], port[15:14]};
            t.reg_rdata        = '0;
            t.hit              = 1'b0;
            t.backing_addr     = '0;
            t.mem_write_enable = 1'b0;
            t.mem_wdata        = '0;
            if (op == CMD_PORT_RD)
            begin
                t.reg_rdata = page_regs[sel];
            end
            else if (op == CMD_PORT_WR)
            begin
                page_regs[sel]      = wdata;
                slot_base[sel[1:0]] = frame_base(sel[2], wdata);
            end
            else if (addr >= WINDOW_START && addr <= WINDOW_END)
            begin
                base = slot_base[addr[15:14]];
                if (base != '0)
                begin
                    t.hit          = 1'b1;
                    t.backing_addr = base + {8'd0, addr[13:0]};
                    if (op == CMD_MEM_WR)
                    begin
                        t.mem_write_enable = 1'b1;
                        t.mem_wdata        = wdata;
                    end
                end
            end
            pending_translations.push_back(t);
        endfunction

        function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
            if (actual !== expected)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
                failures++;
            end
        endfunction

        function void check_response(translation_t got);
            translation_t want;
            if (pending_translations.size() == 0)
            begin
                $error("response transaction with no request outstanding");
                failures++;
                return;
            end
            want = pending_translations.pop_front();
            compare_field("reg_rdata", want.reg_rdata, got.reg_rdata);
            compare_field("hit", want.hit, got.hit);
            compare_field("backing_addr", want.backing_addr, got.backing_addr);
            compare_field("mem_write_enable", want.mem_write_enable, got.mem_write_enable);
            compare_field("mem_wdata", want.mem_wdata, got.mem_wdata);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ems_pfm_req_if req_ch ();
    ems_pfm_rsp_if rsp_ch ();

    window_map_model model;
    bit              throttle;
    int unsigned     cycle_count;

    ems_page_frame_mapper_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Response side: random back-pressure bursts while throttling is on.
    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (throttle && rst_n && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 11) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= rst_n;
            end
        end
    end

    initial
    begin
        translation_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.reg_rdata        = rsp_ch.reg_rdata;
                got.hit              = rsp_ch.hit;
                got.backing_addr     = rsp_ch.backing_addr;
                got.mem_write_enable = rsp_ch.mem_write_enable;
                got.mem_wdata        = rsp_ch.mem_wdata;
                model.check_response(got);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next call either keeps it or idles.
    task automatic send_request(cmd_t op, logic [15:0] port, logic [19:0] addr,
                                logic [7:0] wdata);
        if (throttle && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= op;
        req_ch.io_port  <= port;
        req_ch.mem_addr <= addr;
        req_ch.wdata    <= wdata;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        model.accept_request(op, port, addr, wdata);
        @(negedge clk);
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (model.pending_translations.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes card_enable, then reads it back over the same port.
    task automatic set_card_enable(bit value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CARD_ENABLE_ADDR;
        pwdata  <= {31'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        model.card_en = value;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        model.compare_field("card_enable", value, prdata[0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random_phase(int count);
        cmd_t        op;
        int unsigned pick;
        logic [15:0] port;
        logic [19:0] addr;
        logic [7:0]  wdata;
        for (int n = 0; n < count; n++)
        begin
            pick  = $urandom_range(0, 99);
            port  = 16'($urandom_range(0, 65535));
            addr  = 20'($urandom_range(0, 20'hFFFFF));
            wdata = 8'($urandom_range(0, 255));
            if (pick < 15)
            begin
                op = CMD_PORT_RD;
            end
            else if (pick < 40)
            begin
                op = CMD_PORT_WR;
                // Mostly enabled mappings so that slots get populated.
                if ($urandom_range(0, 3) != 0)
                begin
                    wdata[7] = 1'b1;
                end
            end
            else
            begin
                op = (pick < 70) ? CMD_MEM_RD : CMD_MEM_WR;
                if ($urandom_range(0, 4) != 0)
                begin
                    addr[19:16] = WINDOW_START[19:16];
                end
            end
            send_request(op, port, addr, wdata);
        end
    endtask

    initial
    begin
        model        = new();
        throttle     = 1'b0;
        cycle_count  = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = '0;
        req_ch.io_port  = '0;
        req_ch.mem_addr = '0;
        req_ch.wdata    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Base pages only: lowest and highest base page, first card page
        // refused, window edges and addresses just outside it.
        set_card_enable(1'b0);
        @(negedge clk);
        send_request(CMD_PORT_WR, 16'h0000, 20'h00000, 8'h80);
        send_request(CMD_PORT_WR, 16'h4000, 20'h00000, 8'h97);
        send_request(CMD_PORT_WR, 16'hBFEF, 20'hFFFFF, 8'h98);
        send_request(CMD_PORT_WR, 16'hC010, 20'h00000, 8'h85);
        send_request(CMD_PORT_RD, 16'h0000, 20'h00000, 8'h00);
        send_request(CMD_PORT_RD, 16'hFFFF, 20'hFFFFF, 8'hFF);
        send_request(CMD_MEM_RD, 16'h0000, 20'hD0000, 8'h00);
        send_request(CMD_MEM_WR, 16'hFFFF, 20'hD7FFF, 8'hFF);
        send_request(CMD_MEM_RD, 16'h0000, 20'hDBFFF, 8'h00);
        send_request(CMD_MEM_WR, 16'h0000, 20'hCFFFF, 8'hAA);
        send_request(CMD_MEM_RD, 16'h0000, 20'hE0000, 8'h00);
        send_request(CMD_MEM_WR, 16'h0000, 20'hFFFFF, 8'h00);
        send_request(CMD_PORT_WR, 16'h0010, 20'h00000, 8'h7F);
        send_request(CMD_MEM_RD, 16'h0000, 20'hD0000, 8'h00);
        drain_responses();

        // Card pages: top of card space, last card page in the upper bank,
        // first page past the card, and earlier base mappings surviving.
        set_card_enable(1'b1);
        @(negedge clk);
        send_request(CMD_PORT_WR, 16'h8000, 20'h00000, 8'h98);
        send_request(CMD_PORT_WR, 16'hC010, 20'h00000, 8'hD7);
        send_request(CMD_PORT_WR, 16'h0010, 20'h00000, 8'hD8);
        send_request(CMD_PORT_WR, 16'h0000, 20'h00000, 8'hFF);
        send_request(CMD_MEM_RD, 16'h0000, 20'hDBFFF, 8'h00);
        send_request(CMD_MEM_WR, 16'h0000, 20'hDC000, 8'h5A);
        send_request(CMD_MEM_RD, 16'h0000, 20'hD0123, 8'h00);
        send_request(CMD_PORT_RD, 16'hFFEF, 20'h00000, 8'h00);
        send_request(CMD_MEM_RD, 16'h0000, 20'hD4000, 8'h00);
        drain_responses();

        throttle = 1'b1;
        set_card_enable(1'b0);
        @(negedge clk);
        run_random_phase(PHASE_ITEMS);
        drain_responses();

        set_card_enable(1'b1);
        @(negedge clk);
        run_random_phase(PHASE_ITEMS);
        drain_responses();

        set_card_enable(1'b0);
        @(negedge clk);
        run_random_phase(PHASE_ITEMS);
        drain_responses();

        throttle = 1'b0;
        set_card_enable(1'b1);
        @(negedge clk);
        run_random_phase(PHASE_ITEMS);
        drain_responses();

        repeat (10) @(posedge clk);
        if (model.failures == 0 && model.pending_translations.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
